### rtl/ildu_pkg.sv
// Package: shared types, widths and opcode class ROMs for the length decoder.
package ildu_pkg;

    localparam int WINDOW_BYTES_DEF = 16;
    localparam int POS_W = 5;
    localparam int LEN_W = 8;

    typedef struct packed {
        logic [63:0] code_low;
        logic [63:0] code_high;
    } in_t;

    typedef struct packed {
        logic [4:0] length;
        logic       overrun;
    } out_t;

    // Per-byte classification found by one lane
    typedef struct packed {
        logic [7:0] one;
        logic [7:0] esc;
        logic [7:0] byt;
    } lane_t;

    localparam logic [7:0] CLS_ONE [256] = '{
    8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h51,8'h51,8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h51,8'h20,
    8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h51,8'h51,8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h51,8'h51,
    8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h10,8'h51,8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h10,8'h51,
    8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h10,8'h51,8'h92,8'h92,8'h92,8'h92,8'h52,8'h45,8'h10,8'h51,
    8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h14,8'h14,8'h14,8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,
    8'h51,8'h51,8'h92,8'h92,8'h10,8'h10,8'h12,8'h11,8'h45,8'h86,8'h52,8'h93,8'h51,8'h51,8'h51,8'h51,
    8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,
    8'h93,8'h86,8'h93,8'h93,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,
    8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h47,8'h51,8'h51,8'h51,8'h51,8'h51,
    8'h59,8'h59,8'h59,8'h59,8'h51,8'h51,8'h51,8'h51,8'h52,8'h45,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,
    8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,
    8'h93,8'h93,8'h53,8'h51,8'h70,8'h71,8'h93,8'h86,8'h54,8'h51,8'h53,8'h51,8'h51,8'h52,8'h51,8'h51,
    8'h92,8'h92,8'h92,8'h92,8'h52,8'h52,8'h51,8'h51,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,8'h92,
    8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h45,8'h45,8'h47,8'h52,8'h51,8'h51,8'h51,8'h51,
    8'h10,8'h51,8'h10,8'h10,8'h51,8'h51,8'h63,8'h66,8'h51,8'h51,8'h51,8'h51,8'h51,8'h51,8'h92,8'h92
    };

    localparam logic [7:0] CLS_ESC [256] = '{
    8'h93,8'h93,8'h93,8'h93,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h51,8'h52,8'h51,8'h93,8'h52,8'h94,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h53,8'h53,8'h53,8'h53,8'h53,8'h53,8'h53,8'h53,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h34,8'h51,8'h35,8'h51,8'h51,8'h51,8'h51,8'h51,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h53,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h94,8'h54,8'h54,8'h54,8'h93,8'h93,8'h93,8'h52,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,8'h46,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h52,8'h52,8'h52,8'h93,8'h94,8'h93,8'h51,8'h51,8'h52,8'h52,8'h52,8'h93,8'h94,8'h93,8'h93,8'h93,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h94,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h93,8'h93,8'h94,8'h93,8'h94,8'h94,8'h94,8'h93,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,8'h52,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,
    8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h93,8'h52
    };

endpackage

### rtl/ildu_lane.sv
// One classification lane: looks up both opcode ROMs for one window byte.
module ildu_lane
    import ildu_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] byte_in,
    output lane_t      lane
);

    lane_t lane_reg;

    // Capture byte and both classes when a window arrives
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_reg.one <= CLS_ONE[byte_in];
            lane_reg.esc <= CLS_ESC[byte_in];
            lane_reg.byt <= byte_in;
        end
    end

    assign lane = lane_reg;

endmodule

### rtl/ildu_walker.sv
// Merging stage: walks the lane results byte by byte to find the length.
module ildu_walker
    import ildu_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  lane_t lanes [WINDOW_BYTES],
    output logic  out_valid,
    input  logic  out_stall,
    output out_t  out_data
);

    localparam int IDX_W = $clog2(WINDOW_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLS   = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;

    localparam logic [2:0] K_ONE   = 3'd0;
    localparam logic [2:0] K_ESC   = 3'd1;
    localparam logic [2:0] K_GRP3  = 3'd2;
    localparam logic [2:0] K_VEX   = 3'd3;
    localparam logic [2:0] K_MODRM = 3'd4;
    localparam logic [2:0] K_SIB   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       pfx_reg, pfx_next;   // bit0: 66 seen, bit1: REX.W seen
    logic [7:0]       cls_reg, cls_next;
    logic             ovr_reg, ovr_next;
    logic             ov_reg;
    out_t             od_reg;

    lane_t            r;
    logic [7:0]       g3cls;
    logic [4:0]       vexc;
    logic [LEN_W-1:0] m_base, m_len;
    logic             m_fin;
    logic [LEN_W-1:0] cadd, p66, pw;

    assign r    = lanes[idx_reg[IDX_W-1:0]];
    assign cadd = LEN_W'(cls_reg[3:0]);
    assign p66  = pfx_reg[0] ? LEN_W'(2) : LEN_W'(0);
    assign pw   = pfx_reg[1] ? LEN_W'(4) : LEN_W'(0);

    // Group 3: reg field selects test (with immediate) or not
    always_comb
    begin
        if ((r.byt & 8'h38) != 8'h00)
            g3cls = 8'h02;
        else if (pfx_reg[0] && cls_reg == 8'h66)
            g3cls = 8'h04;
        else
            g3cls = cls_reg;
    end

    assign vexc = r.byt[4:0];

    // ModR/M displacement and SIB detection
    always_comb
    begin
        m_base = (kind_reg == K_GRP3) ? len_reg + LEN_W'(g3cls[3:0]) : len_reg;
        m_fin  = 1'b1;
        m_len  = m_base;
        unique case (r.byt[7:6])
            2'd0:
            begin
                if (r.byt[2:0] == 3'd5)
                    m_len = m_base + LEN_W'(4);
                else if (r.byt[2:0] == 3'd4)
                begin
                    m_len = m_base + LEN_W'(1);
                    m_fin = 1'b0;
                end
            end
            2'd1:
            begin
                m_len = m_base + LEN_W'(1) + ((r.byt[2:0] == 3'd4) ? LEN_W'(1) : LEN_W'(0));
            end
            2'd2:
            begin
                m_len = m_base + LEN_W'(4) + ((r.byt[2:0] == 3'd4) ? LEN_W'(1) : LEN_W'(0));
            end
            default:
            begin
                m_len = m_base;
            end
        endcase
    end

    // Walk control
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        pfx_next   = pfx_reg;
        cls_next   = cls_reg;
        ovr_next   = ovr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = K_ONE;
                    pos_next   = '0;
                    idx_next   = '0;
                    len_next   = '0;
                    pfx_next   = '0;
                    ovr_next   = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_CLS:
            begin
                unique case (cls_reg[7:4])
                    4'd0:
                    begin
                        len_next   = len_reg + LEN_W'(cls_reg) + pw;
                        state_next = ST_DONE;
                    end
                    4'd1:
                    begin
                        pfx_next   = pfx_reg | cls_reg[2:1];
                        pos_next   = pos_reg + POS_W'(1);
                        idx_next   = pos_reg + POS_W'(1);
                        len_next   = len_reg + LEN_W'(1);
                        kind_next  = K_ONE;
                        state_next = ST_FETCH;
                    end
                    4'd2:
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        idx_next   = pos_reg + POS_W'(1);
                        kind_next  = K_ESC;
                        state_next = ST_FETCH;
                    end
                    4'd3:
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        idx_next   = pos_reg + POS_W'(2);
                        len_next   = len_reg + cadd;
                        kind_next  = K_MODRM;
                        state_next = ST_FETCH;
                    end
                    4'd4:
                    begin
                        len_next   = len_reg - p66 + cadd;
                        state_next = ST_DONE;
                    end
                    4'd5:
                    begin
                        len_next   = len_reg + cadd;
                        state_next = ST_DONE;
                    end
                    4'd6:
                    begin
                        idx_next   = pos_reg + POS_W'(1);
                        kind_next  = K_GRP3;
                        state_next = ST_FETCH;
                    end
                    4'd7:
                    begin
                        if (cls_reg == 8'h70)
                        begin
                            pos_next  = pos_reg + POS_W'(1);
                            idx_next  = pos_reg + POS_W'(1);
                            kind_next = K_VEX;
                        end
                        else
                        begin
                            pos_next  = pos_reg + POS_W'(2);
                            idx_next  = pos_reg + POS_W'(2);
                            len_next  = len_reg + LEN_W'(1);
                            kind_next = K_ESC;
                        end
                        state_next = ST_FETCH;
                    end
                    4'd8:
                    begin
                        idx_next   = pos_reg + POS_W'(1);
                        len_next   = len_reg - p66 + cadd;
                        kind_next  = K_MODRM;
                        state_next = ST_FETCH;
                    end
                    default:
                    begin
                        idx_next   = pos_reg + POS_W'(1);
                        len_next   = len_reg + cadd;
                        kind_next  = K_MODRM;
                        state_next = ST_FETCH;
                    end
                endcase
            end
            ST_FETCH:
            begin
                if (idx_reg >= POS_W'(WINDOW_BYTES))
                begin
                    ovr_next   = 1'b1;
                    len_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    unique case (kind_reg)
                        K_ONE:
                        begin
                            cls_next   = r.one;
                            state_next = ST_CLS;
                        end
                        K_ESC:
                        begin
                            cls_next   = r.esc;
                            state_next = ST_CLS;
                        end
                        K_VEX:
                        begin
                            if (vexc >= 5'd2)
                            begin
                                pos_next  = pos_reg + POS_W'(2);
                                idx_next  = pos_reg + POS_W'(3);
                                len_next  = len_reg + LEN_W'(3) + LEN_W'(vexc[3:0]);
                                kind_next = K_MODRM;
                            end
                            else
                            begin
                                pos_next  = pos_reg + POS_W'(2);
                                idx_next  = pos_reg + POS_W'(2);
                                len_next  = len_reg + LEN_W'(2);
                                kind_next = K_ESC;
                            end
                        end
                        K_GRP3, K_MODRM:
                        begin
                            len_next = m_len;
                            if (m_fin)
                                state_next = ST_DONE;
                            else
                            begin
                                idx_next  = idx_reg + POS_W'(1);
                                kind_next = K_SIB;
                            end
                        end
                        K_SIB:
                        begin
                            if (r.byt[2:0] == 3'd5)
                                len_next = len_reg + LEN_W'(4);
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // Walk datapath and result register
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        pfx_reg  <= pfx_next;
        cls_reg  <= cls_next;
        ovr_reg  <= ovr_next;
        if (state_reg == ST_DONE && (!ov_reg || !out_stall))
        begin
            od_reg.length  <= len_reg[4:0];
            od_reg.overrun <= ovr_reg;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

### rtl/x86_instruction_length_decode_unit.sv
// Top level of the x86-64 instruction length decoder.
// Takes one window of code per transaction and returns the byte length of the
// instruction at window byte 0, or overrun with length 0 when the decode needs
// a byte past the window. On acceptance, one lane per window byte looks up its
// one-byte and 0F-map class in parallel; the walker then visits one byte per
// step, going through its fetch and classify states for prefixes and escapes
// and through its fetch state alone for ModR/M and SIB. The result is handed
// over through an output register. One window is decoded at a time; the next
// window is taken once the result is in the output register.
module x86_instruction_length_decode_unit
    import ildu_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic        busy;
    logic        load;
    logic [127:0] window;
    lane_t       lanes [WINDOW_BYTES];

    assign in_stall = busy;
    assign load     = in_valid && !busy;
    assign window   = {in_data.code_high, in_data.code_low};

    // Classification lanes, one per window byte
    for (genvar i = 0; i < WINDOW_BYTES; i++)
    begin : g_lane
        ildu_lane u_lane (
            .clk     (clk),
            .load    (load),
            .byte_in (window[8*i +: 8]),
            .lane    (lanes[i])
        );
    end

    ildu_walker #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (load),
        .busy      (busy),
        .lanes     (lanes),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
